### rtl/core/strs_pkg.sv
package strs_pkg;

  // Command codes carried on the request channel
  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam int unsigned SUM_W   = 64;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned RANGE_W = 11;

  // Controller to datapath commands
  typedef struct packed {
    logic clr;       // write zero at the clear pointer, advance it
    logic load;      // request transfer: capture the command fields
    logic set_leaf;  // write the leaf, read its sibling
    logic set_up;    // write parent = carry + sibling, read parent's sibling
    logic q_step;    // one query level: issue reads, move the bounds up
    logic q_acc;     // fold returned read data into the accumulator
    logic q_out;     // load the accumulator into the result register
  } strs_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;   // clear pointer at the last node
    logic req_query;  // request payload holds a query
    logic idx_ok;     // request leaf index lies inside the tree
    logic up_last;    // this update step writes the root
    logic walk_last;  // bounds meet after this query step
    logic out_free;   // result register can take a new sum
  } strs_sts_t;

endpackage

### rtl/core/strs_if.sv
// Request channel: one command per transfer
interface strs_req_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  cmd;
  logic [strs_pkg::INDEX_W-1:0]          index;
  logic signed [strs_pkg::VALUE_W-1:0]   value;
  logic [strs_pkg::RANGE_W-1:0]          range_low;
  logic [strs_pkg::RANGE_W-1:0]          range_high;

  modport source (output valid, cmd, index, value, range_low, range_high, input ready);
  modport sink   (input valid, cmd, index, value, range_low, range_high, output ready);
endinterface

// Response channel: one sum per query
interface strs_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [strs_pkg::SUM_W-1:0]   sum;

  modport source (output valid, sum, input ready);
  modport sink   (input valid, sum, output ready);
endinterface

### rtl/core/strs_ctrl.sv
module strs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  strs_pkg::strs_sts_t sts,
  output strs_pkg::strs_ctl_t ctl
);

  typedef enum logic [6:0] {
    ST_CLEAR    = 7'b0000001,
    ST_IDLE     = 7'b0000010,
    ST_SET_LEAF = 7'b0000100,
    ST_SET_UP   = 7'b0001000,
    ST_Q_WALK   = 7'b0010000,
    ST_Q_ACC    = 7'b0100000,
    ST_Q_OUT    = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    ctl        = '0;
    case (state)
      ST_CLEAR: begin
        ctl.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctl.load = 1'b1;
          if (sts.req_query) begin
            state_next = ST_Q_WALK;
          end else if (sts.idx_ok) begin
            state_next = ST_SET_LEAF;
          end
        end
      end
      ST_SET_LEAF: begin
        ctl.set_leaf = 1'b1;
        state_next   = ST_SET_UP;
      end
      ST_SET_UP: begin
        ctl.set_up = 1'b1;
        if (sts.up_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_Q_WALK: begin
        ctl.q_step = 1'b1;
        ctl.q_acc  = 1'b1;
        if (sts.walk_last) begin
          state_next = ST_Q_ACC;
        end
      end
      ST_Q_ACC: begin
        ctl.q_acc  = 1'b1;
        state_next = ST_Q_OUT;
      end
      ST_Q_OUT: begin
        if (sts.out_free) begin
          ctl.q_out  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

### rtl/core/strs_dp.sv
module strs_dp #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  strs_pkg::strs_ctl_t                  ctl,
  output strs_pkg::strs_sts_t                  sts,
  input  logic                                 req_cmd,
  input  logic [strs_pkg::INDEX_W-1:0]         req_index,
  input  logic signed [strs_pkg::VALUE_W-1:0]  req_value,
  input  logic [strs_pkg::RANGE_W-1:0]         req_range_low,
  input  logic [strs_pkg::RANGE_W-1:0]         req_range_high,
  output logic                                 rsp_valid,
  input  logic                                 rsp_ready,
  output logic signed [strs_pkg::SUM_W-1:0]    rsp_sum
);

  localparam int unsigned LW    = $clog2(LEAVES);
  localparam int unsigned AW    = LW + 1;        // node address
  localparam int unsigned QW    = LW + 2;        // query bound, reaches 2*LEAVES
  localparam int unsigned NODES = 2 * LEAVES;
  localparam int unsigned SW    = strs_pkg::SUM_W;

  // Tree storage, node 1 is the root, leaf i is node LEAVES+i
  logic [SW-1:0] tree [NODES];

  logic [AW-1:0] clr_addr;
  logic [AW-1:0] node;
  logic [SW-1:0] carry;
  logic [QW-1:0] lo;
  logic [QW-1:0] hi;
  logic [SW-1:0] acc;
  logic [SW-1:0] rd0;
  logic [SW-1:0] rd1;
  logic          rd0_en;
  logic          rd1_en;
  logic [SW-1:0] sum_q;
  logic          out_valid;

  logic          we;
  logic [AW-1:0] waddr;
  logic [SW-1:0] wdata;
  logic [AW-1:0] raddr0;
  logic [AW-1:0] raddr1;
  logic [AW-1:0] parent;
  logic [SW-1:0] up_sum;
  logic          active;
  logic [QW-1:0] lo_next;
  logic [QW-1:0] hi_next;
  logic [QW-1:0] lo_init;
  logic [QW-1:0] hi_init;
  logic [AW-1:0] leaf_node;

  // Request decode
  assign leaf_node = AW'(32'(req_index) + 32'(LEAVES));
  assign lo_init   = (32'(req_range_low) > 32'(LEAVES))
                     ? QW'(2 * LEAVES) : QW'(32'(req_range_low) + 32'(LEAVES));
  assign hi_init   = (32'(req_range_high) > 32'(LEAVES))
                     ? QW'(2 * LEAVES) : QW'(32'(req_range_high) + 32'(LEAVES));

  // Update walk
  assign parent = node >> 1;
  assign up_sum = carry + rd0;

  // Query walk: odd low bound takes node lo, odd high bound takes node hi-1
  assign active  = lo < hi;
  assign lo_next = (lo >> 1) + QW'(lo[0]);
  assign hi_next = hi >> 1;

  // Status
  assign sts.clr_last  = &clr_addr;
  assign sts.req_query = (req_cmd == strs_pkg::CMD_QUERY);
  assign sts.idx_ok    = 32'(req_index) < 32'(LEAVES);
  assign sts.up_last   = (parent == AW'(1));
  assign sts.walk_last = !active || !(lo_next < hi_next);
  assign sts.out_free  = !out_valid || rsp_ready;

  // Write port and read address select
  always_comb begin
    we     = 1'b0;
    waddr  = node;
    wdata  = carry;
    raddr0 = lo[AW-1:0];
    raddr1 = {hi[AW-1:1], 1'b0};
    if (ctl.clr) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else if (ctl.set_leaf) begin
      we     = 1'b1;
      raddr0 = {node[AW-1:1], ~node[0]};
    end else if (ctl.set_up) begin
      we     = 1'b1;
      waddr  = parent;
      wdata  = up_sum;
      raddr0 = {parent[AW-1:1], ~parent[0]};
    end
  end

  // Tree memory, registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      tree[waddr] <= wdata;
    end
    rd0 <= tree[raddr0];
    rd1 <= tree[raddr1];
  end

  // Clear pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clr) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      node  <= leaf_node;
      carry <= {{(SW - strs_pkg::VALUE_W){req_value[strs_pkg::VALUE_W-1]}}, req_value};
      lo    <= lo_init;
      hi    <= hi_init;
    end else if (ctl.set_up) begin
      node  <= parent;
      carry <= up_sum;
    end else if (ctl.q_step && active) begin
      lo <= lo_next;
      hi <= hi_next;
    end
  end

  // Read enables are registered alongside the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd0_en <= 1'b0;
      rd1_en <= 1'b0;
    end else begin
      rd0_en <= ctl.q_step && active && lo[0];
      rd1_en <= ctl.q_step && active && hi[0];
    end
  end

  // Accumulator
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc <= '0;
    end else if (ctl.q_acc) begin
      acc <= acc + (rd0_en ? rd0 : '0) + (rd1_en ? rd1 : '0);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.q_out) begin
      out_valid <= 1'b1;
    end else if (rsp_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.q_out) begin
      sum_q <= acc;
    end
  end

  assign rsp_valid = out_valid;
  assign rsp_sum   = sum_q;

endmodule

### rtl/core/segment_tree_range_sum_top.sv
// Channel  Role  Payload                                          Moves
// req      sink  cmd, index, value, range_low, range_high         one command per transfer
// rsp      src   sum                                              one sum per query transfer
//
// A set writes the leaf, then one ancestor per cycle through the single write
// port. A query walks one tree level per cycle over two read ports until the
// bounds meet, then does accumulate and result load. After reset a clearing
// pass zeroes all 2*LEAVES nodes, one per cycle; req is not ready during it.
// A held result on rsp stalls only the next query's final step.
module segment_tree_range_sum_top #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  strs_req_if.sink          req,
  strs_rsp_if.source        rsp
);

  strs_pkg::strs_ctl_t ctl;
  strs_pkg::strs_sts_t sts;

  strs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  strs_dp #(
    .LEAVES (LEAVES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .sts            (sts),
    .req_cmd        (req.cmd),
    .req_index      (req.index),
    .req_value      (req.value),
    .req_range_low  (req.range_low),
    .req_range_high (req.range_high),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_sum        (rsp.sum)
  );

endmodule
